[hw/rtl/ncrpll_pkg.sv]
// ----------------------------------------------------------------------------
// ncrpll_pkg
// shared widths, codes and reset values of the clock recovery loop
// ----------------------------------------------------------------------------
package ncrpll_pkg;

    localparam int FRAME_W    = 32;
    localparam int ADDR_W     = 32;
    localparam int PERIOD_W   = 16;
    localparam int OFFSET_W   = 33;
    localparam int WINDOW_W   = 16;
    localparam int UPD_W      = 7;
    localparam int FPS_W      = 16;
    localparam int BURST_W    = 10;
    localparam int CFG_DATA_W = 16;

    // event codes
    typedef enum logic [1:0] {
        CMD_PACKET      = 2'd0,
        CMD_PERIOD_TICK = 2'd1,
        CMD_SLOT_TICK   = 2'd2,
        CMD_WATCHDOG    = 2'd3
    } cmd_t;

    // register indexes
    typedef enum logic [1:0] {
        REG_RESET_WINDOW    = 2'd0,
        REG_UPDATE_PERIOD   = 2'd1,
        REG_FRAMES_PER_SLOT = 2'd2,
        REG_BURST_LENGTH    = 2'd3
    } cfg_idx_t;

    localparam logic [WINDOW_W-1:0] RESET_WINDOW_INIT    = 16'd4800;
    localparam logic [UPD_W-1:0]    UPDATE_PERIOD_INIT   = 7'd50;
    localparam logic [FPS_W-1:0]    FRAMES_PER_SLOT_INIT = 16'd240;
    localparam logic [BURST_W-1:0]  BURST_LENGTH_INIT    = 10'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_INIT          = 16'd500;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX           = 16'hFFFF;

    // offset divisor 240 = 16 * 15; x / 15 = (x * RECIP_15) >> 35 for any 32 bit x
    localparam int                  DIV_SHIFT = 4;
    localparam logic [31:0]         RECIP_15  = 32'h8888_8889;
    localparam int                  RECIP_SH  = 35;

endpackage

[hw/rtl/ncrpll_event_if.sv]
// ----------------------------------------------------------------------------
// ncrpll_event_if
// event word channel: clock packets, period and slot ticks, watchdog timeouts
// ----------------------------------------------------------------------------
interface ncrpll_event_if import ncrpll_pkg::*; ();

    logic                valid;
    logic                ready;
    cmd_t                command;
    logic [FRAME_W-1:0]  remote_frame;
    logic [ADDR_W-1:0]   sender_address;

    modport source (output valid, output command, output remote_frame,
                    output sender_address, input ready);
    modport sink   (input valid, input command, input remote_frame,
                    input sender_address, output ready);

endinterface

[hw/rtl/ncrpll_status_if.sv]
// ----------------------------------------------------------------------------
// ncrpll_status_if
// status word channel, one word per event
// ----------------------------------------------------------------------------
interface ncrpll_status_if import ncrpll_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic                       send_packet;
    logic                       loop_reset;
    logic                       period_updated;
    logic [PERIOD_W-1:0]        period_ms;
    logic signed [OFFSET_W-1:0] phase_offset;
    logic                       watchdog_alarm;
    logic                       watchdog_changed;
    logic                       source_changed;
    logic [ADDR_W-1:0]          current_source;

    modport source (output valid, output send_packet, output loop_reset,
                    output period_updated, output period_ms, output phase_offset,
                    output watchdog_alarm, output watchdog_changed,
                    output source_changed, output current_source, input ready);
    modport sink   (input valid, input send_packet, input loop_reset,
                    input period_updated, input period_ms, input phase_offset,
                    input watchdog_alarm, input watchdog_changed,
                    input source_changed, input current_source, output ready);

endinterface

[hw/rtl/ncrpll_cfg_if.sv]
// ----------------------------------------------------------------------------
// ncrpll_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface ncrpll_cfg_if import ncrpll_pkg::*; ();

    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

[hw/rtl/network_clock_recovery_pll_core.sv]
// ----------------------------------------------------------------------------
// network_clock_recovery_pll_core
// media clock recovery loop driven by clock packets and timer events
// ----------------------------------------------------------------------------
// path: an accepted word passes the event register stage, then the status
//   register stage, after which its status word is valid
// throughput: one word per cycle while status.ready is high, set by the single
//   event stage pass; with both stages full, events.ready follows status.ready
// reset: rst_n clears the state registers at once, period 500, config at defaults
// ----------------------------------------------------------------------------
module network_clock_recovery_pll_core
    import ncrpll_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ncrpll_event_if.sink        events,
    ncrpll_status_if.source     status,
    ncrpll_cfg_if.sink          cfg
);

    // configuration registers
    logic [WINDOW_W-1:0]  reset_window_reg;
    logic [UPD_W-1:0]     update_period_reg;
    logic [FPS_W-1:0]     frames_per_slot_reg;
    logic [BURST_W-1:0]   burst_length_reg;

    // event register stage
    logic                 ev_valid_reg;
    cmd_t                 ev_command_reg;
    logic [FRAME_W-1:0]   ev_remote_reg;
    logic [ADDR_W-1:0]    ev_addr_reg;

    // loop state
    logic [FRAME_W-1:0]   local_frame_reg,  local_frame_next;
    logic [FRAME_W-1:0]   min_remote_reg,   min_remote_next;
    logic [FRAME_W-1:0]   min_local_reg,    min_local_next;
    logic [UPD_W-1:0]     packet_count_reg, packet_count_next;
    logic [OFFSET_W-1:0]  setpoint_reg,     setpoint_next;
    logic [PERIOD_W-1:0]  period_reg,       period_next;
    logic [BURST_W-1:0]   slots_left_reg,   slots_left_next;
    logic                 alarm_reg,        alarm_next;
    logic [ADDR_W-1:0]    source_reg,       source_next;
    logic                 source_known_reg, source_known_next;

    // status register stage
    logic                 out_valid_reg;
    logic                 send_reg,         send_next;
    logic                 loop_reset_reg,   loop_reset_next;
    logic                 updated_reg,      updated_next;
    logic                 wd_changed_reg,   wd_changed_next;
    logic                 src_changed_reg,  src_changed_next;

    // handshake
    logic                 stage_fire;
    assign stage_fire   = ev_valid_reg && (!out_valid_reg || status.ready);
    assign events.ready = !ev_valid_reg || stage_fire;
    assign cfg.ready    = 1'b1;

    // ------------------------------------------------------------------------
    // datapath of the event stage
    // ------------------------------------------------------------------------
    logic [FRAME_W:0]     frame_gap;      // local minus remote, 33 bits
    logic [FRAME_W:0]     frame_dist;     // its magnitude
    logic                 window_hit;
    logic [FRAME_W-1:0]   offset_now;     // remote minus local, modulo 2^32
    logic [FRAME_W-1:0]   offset_min;
    logic                 take_min;
    logic                 do_update;
    logic [OFFSET_W-1:0]  new_diff;       // signed offset of the kept minimum
    logic [OFFSET_W:0]    delta;          // signed change against the setpoint
    logic [OFFSET_W-1:0]  delta_mag;
    logic [28:0]          delta_div16;
    logic [63:0]          recip_prod;
    logic [25:0]          step;           // |delta| / 240
    logic signed [27:0]   period_wide;
    logic [BURST_W-1:0]   slots_base;
    logic                 emit;

    always_comb
    begin
        frame_gap   = {1'b0, local_frame_reg} - {1'b0, ev_remote_reg};
        frame_dist  = frame_gap[FRAME_W] ? ((FRAME_W+1)'(0) - frame_gap) : frame_gap;
        window_hit  = frame_dist > {{(FRAME_W+1-WINDOW_W){1'b0}}, reset_window_reg};

        offset_now  = ev_remote_reg - local_frame_reg;
        offset_min  = min_remote_reg - min_local_reg;
        // first packet of a round always latches, negative offsets rank large
        take_min    = (packet_count_reg == '0) || (offset_now < offset_min);
        do_update   = packet_count_reg >= update_period_reg;

        // default: state holds, flags clear
        local_frame_next  = local_frame_reg;
        min_remote_next   = min_remote_reg;
        min_local_next    = min_local_reg;
        packet_count_next = packet_count_reg;
        setpoint_next     = setpoint_reg;
        period_next       = period_reg;
        slots_left_next   = slots_left_reg;
        alarm_next        = alarm_reg;
        source_next       = source_reg;
        source_known_next = source_known_reg;
        send_next         = 1'b0;
        loop_reset_next   = 1'b0;
        updated_next      = 1'b0;
        wd_changed_next   = 1'b0;
        src_changed_next  = 1'b0;

        if (take_min)
        begin
            min_remote_next = ev_remote_reg;
            min_local_next  = local_frame_reg;
        end

        // period correction from the freshly kept minimum
        new_diff    = {1'b0, min_remote_next} - {1'b0, min_local_next};
        delta       = {new_diff[OFFSET_W-1], new_diff}
                    - {setpoint_reg[OFFSET_W-1], setpoint_reg};
        delta_mag   = delta[OFFSET_W] ? OFFSET_W'((OFFSET_W+1)'(0) - delta)
                                      : delta[OFFSET_W-1:0];
        delta_div16 = delta_mag[OFFSET_W-1:DIV_SHIFT];
        recip_prod  = {3'b000, delta_div16} * RECIP_15;
        step        = recip_prod[RECIP_SH+25:RECIP_SH];
        if (delta[OFFSET_W])
        begin
            period_wide = $signed({12'd0, period_reg}) + $signed({2'b00, step});
        end
        else
        begin
            period_wide = $signed({12'd0, period_reg}) - $signed({2'b00, step});
        end

        // burst slots
        slots_base = (ev_command_reg == CMD_PERIOD_TICK) ? burst_length_reg
                                                         : slots_left_reg;
        emit       = (slots_base != '0);

        case (ev_command_reg)
            CMD_PACKET:
            begin
                if (window_hit)
                begin
                    // snap to the remote frame; count and minimum stay
                    min_remote_next = min_remote_reg;
                    min_local_next  = min_local_reg;
                    local_frame_next = ev_remote_reg;
                    setpoint_next    = '0;
                    loop_reset_next  = 1'b1;
                end
                else if (do_update)
                begin
                    if (period_wide < 0)
                    begin
                        period_next = '0;
                    end
                    else if (period_wide > $signed({12'd0, PERIOD_MAX}))
                    begin
                        period_next = PERIOD_MAX;
                    end
                    else
                    begin
                        period_next = period_wide[PERIOD_W-1:0];
                    end
                    setpoint_next     = new_diff;
                    packet_count_next = '0;
                    updated_next      = 1'b1;
                end
                else
                begin
                    packet_count_next = packet_count_reg + UPD_W'(1);
                end
                if (!source_known_reg || (ev_addr_reg != source_reg))
                begin
                    source_next       = ev_addr_reg;
                    source_known_next = 1'b1;
                    src_changed_next  = 1'b1;
                end
                if (alarm_reg)
                begin
                    alarm_next      = 1'b0;
                    wd_changed_next = 1'b1;
                end
            end
            CMD_PERIOD_TICK, CMD_SLOT_TICK:
            begin
                min_remote_next = min_remote_reg;
                min_local_next  = min_local_reg;
                slots_left_next = emit ? (slots_base - BURST_W'(1)) : slots_base;
                if (emit)
                begin
                    local_frame_next = local_frame_reg
                                     + {{(FRAME_W-FPS_W){1'b0}}, frames_per_slot_reg};
                end
                send_next = emit;
            end
            default:
            begin
                // watchdog timeout, raised again on every repeat
                min_remote_next = min_remote_reg;
                min_local_next  = min_local_reg;
                alarm_next      = 1'b1;
                wd_changed_next = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_window_reg    <= RESET_WINDOW_INIT;
            update_period_reg   <= UPDATE_PERIOD_INIT;
            frames_per_slot_reg <= FRAMES_PER_SLOT_INIT;
            burst_length_reg    <= BURST_LENGTH_INIT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_RESET_WINDOW:    reset_window_reg    <= cfg.data[WINDOW_W-1:0];
                REG_UPDATE_PERIOD:   update_period_reg   <= cfg.data[UPD_W-1:0];
                REG_FRAMES_PER_SLOT: frames_per_slot_reg <= cfg.data[FPS_W-1:0];
                REG_BURST_LENGTH:    burst_length_reg    <= cfg.data[BURST_W-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // event register stage: control
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (events.ready)
        begin
            ev_valid_reg <= events.valid;
        end
    end

    // event payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            ev_command_reg <= events.command;
            ev_remote_reg  <= events.remote_frame;
            ev_addr_reg    <= events.sender_address;
        end
    end

    // ------------------------------------------------------------------------
    // loop state and status register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_frame_reg  <= '0;
            min_remote_reg   <= '0;
            min_local_reg    <= '0;
            packet_count_reg <= '0;
            setpoint_reg     <= '0;
            period_reg       <= PERIOD_INIT;
            slots_left_reg   <= '0;
            alarm_reg        <= 1'b0;
            source_reg       <= '0;
            source_known_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (stage_fire)
            begin
                local_frame_reg  <= local_frame_next;
                min_remote_reg   <= min_remote_next;
                min_local_reg    <= min_local_next;
                packet_count_reg <= packet_count_next;
                setpoint_reg     <= setpoint_next;
                period_reg       <= period_next;
                slots_left_reg   <= slots_left_next;
                alarm_reg        <= alarm_next;
                source_reg       <= source_next;
                source_known_reg <= source_known_next;
                out_valid_reg    <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-word flags, no reset needed
    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            send_reg        <= send_next;
            loop_reset_reg  <= loop_reset_next;
            updated_reg     <= updated_next;
            wd_changed_reg  <= wd_changed_next;
            src_changed_reg <= src_changed_next;
        end
    end

    // status word: flags from the last event, the rest from live state
    assign status.valid            = out_valid_reg;
    assign status.send_packet      = send_reg;
    assign status.loop_reset       = loop_reset_reg;
    assign status.period_updated   = updated_reg;
    assign status.period_ms        = period_reg;
    assign status.phase_offset     = $signed(setpoint_reg);
    assign status.watchdog_alarm   = alarm_reg;
    assign status.watchdog_changed = wd_changed_reg;
    assign status.source_changed   = src_changed_reg;
    assign status.current_source   = source_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // a loop reset and a period correction exclude each other
    assert property (@(posedge clk) disable iff (!rst_n)
        status.valid |-> !(status.loop_reset && status.period_updated))
        else $error("loop reset and period update on one word");

    // a loop reset always clears the reported offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.loop_reset) |-> (status.phase_offset == '0))
        else $error("phase offset not cleared on loop reset");

    // a packet slot never comes with packet-only flags
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.send_packet) |->
            !(status.loop_reset || status.source_changed || status.period_updated))
        else $error("slot emitted on a clock packet");

    // a held event stage keeps its word while the status side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && !stage_fire) |=> (ev_valid_reg && $stable(ev_command_reg)))
        else $error("event stage dropped a stalled word");

endmodule
